// ===== rtl/core/kenc_pkg.sv =====
// Shared types and constants for the keypad and encoder event front end.
// Used by kenc_front, kenc_fifo, kenc_back and the top level; no dependencies.
package kenc_pkg;

	localparam int KEY_SLOTS = 16;

	// Positions in the pending-event mask: keys first, then switch click, then detent.
	localparam int MASK_CLICK_PRESS   = KEY_SLOTS;
	localparam int MASK_CLICK_RELEASE = KEY_SLOTS + 1;
	localparam int MASK_DETENT        = KEY_SLOTS + 2;
	localparam int MASK_W             = KEY_SLOTS + 3;

	// Register index, taken from paddr[2].
	localparam logic REG_STABLE_TICKS    = 1'b0;
	localparam logic REG_STEPS_PER_CLICK = 1'b1;

	localparam logic [7:0] STABLE_TICKS_RESET    = 8'd5;
	localparam logic [4:0] STEPS_PER_CLICK_RESET = 5'd4;

	// Quadrature transition table, index {prior A, prior B, A, B}.
	localparam logic signed [1:0] QUAD_TABLE [16] = '{
		2'sd0, -2'sd1, 2'sd1, 2'sd0,
		2'sd1, 2'sd0, 2'sd0, -2'sd1,
		-2'sd1, 2'sd0, 2'sd0, 2'sd1,
		2'sd0, 2'sd1, -2'sd1, 2'sd0
	};

	// One classified sample, as passed from the front to the back.
	typedef struct packed {
		logic [KEY_SLOTS-1:0] key_evt;
		logic [KEY_SLOTS-1:0] key_press;
		logic                 click;
		logic                 detent;
		logic [3:0]           detent_index;
	} kenc_rec_t;

endpackage

// ===== rtl/core/keypad_encoder_event_front_end.sv =====
// Keypad and rotary encoder event front end, top level.
// Input channel (push/full): one pin sample per item - eight active-low keys, the
// active-low encoder switch, encoder phases A and B and a scan tick flag.
// Result channel (empty/pop): events, each an index (keys, cw, ccw, switch, held cw,
// held ccw), a press/release flag and a flag on the last event of its sample.
// Config port (APB): stable tick count at 0x0, steps_per_click at 0x4; pready tied high.
// A sample is taken every cycle while the record queue has room; decode, debounce
// and detent checks finish in the cycle it is accepted. A sample that yields events
// is written to the record queue, loaded into the back end's pending mask and then
// into the output register. The output serializer emits one event per cycle while
// the output register is empty or popped, up to 11 events per sample with eight
// keys; a sample with none is not queued. Sustained rate is set by the serializer.
// A stalled result holds on the ports; the queue fills and then full rises.
// Reset clears all debounce state, the encoder counts, the prior phase and the
// queue, and loads a stable tick count of 5 and steps_per_click = 4.
// Depends on kenc_pkg, kenc_front, kenc_fifo, kenc_back.
module keypad_encoder_event_front_end #(
	parameter int KEY_COUNT   = 8,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  key_levels,
	input  logic        switch_level,
	input  logic        phase_a,
	input  logic        phase_b,
	input  logic        scan_tick,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  event_index,
	output logic        is_press,
	output logic        last_of_run,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] stable_ticks_q;
	logic [4:0] steps_per_click_q;
	logic       cfg_write;
	logic       accept;

	kenc_pkg::kenc_rec_t rec;
	kenc_pkg::kenc_rec_t head;
	logic                rec_any;
	logic                q_full;
	logic                q_empty;
	logic                head_pop;
	logic                out_valid;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_ticks_q    <= kenc_pkg::STABLE_TICKS_RESET;
			steps_per_click_q <= kenc_pkg::STEPS_PER_CLICK_RESET;
		end else if (cfg_write) begin
			if (paddr[2] == kenc_pkg::REG_STABLE_TICKS) begin
				stable_ticks_q <= pwdata[7:0];
			end else begin
				steps_per_click_q <= pwdata[4:0];
			end
		end
	end

	assign prdata = (paddr[2] == kenc_pkg::REG_STEPS_PER_CLICK)
		? {27'd0, steps_per_click_q} : {24'd0, stable_ticks_q};

	assign full   = q_full;
	assign accept = push && !q_full;

	kenc_front #(
		.KEY_COUNT(KEY_COUNT)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.key_levels     (key_levels),
		.switch_level   (switch_level),
		.phase_a        (phase_a),
		.phase_b        (phase_b),
		.scan_tick      (scan_tick),
		.stable_ticks   (stable_ticks_q),
		.steps_per_click(steps_per_click_q),
		.rec            (rec),
		.rec_any        (rec_any)
	);

	kenc_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (accept && rec_any),
		.wdata (rec),
		.pop   (head_pop),
		.rdata (head),
		.full  (q_full),
		.empty (q_empty)
	);

	kenc_back #(
		.KEY_COUNT(KEY_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (q_empty),
		.head_pop   (head_pop),
		.pop        (pop),
		.out_valid  (out_valid),
		.event_index(event_index),
		.is_press   (is_press),
		.last_of_run(last_of_run)
	);

	assign empty = !out_valid;

endmodule

// ===== rtl/core/kenc_front.sv =====
// Front part: quadrature decode, key and switch debounce, detent detection.
// Produces one classified record per accepted sample. Depends on kenc_pkg.
module kenc_front #(
	parameter int KEY_COUNT = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          key_levels,
	input  logic                switch_level,
	input  logic                phase_a,
	input  logic                phase_b,
	input  logic                scan_tick,
	input  logic [7:0]          stable_ticks,
	input  logic [4:0]          steps_per_click,
	output kenc_pkg::kenc_rec_t rec,
	output logic                rec_any
);

	logic [KEY_COUNT-1:0] key_stable_q;
	logic [7:0]           key_cnt_q [KEY_COUNT];
	logic [KEY_COUNT-1:0] key_reading;
	logic [KEY_COUNT-1:0] key_acc;

	logic        sw_stable_q;
	logic [7:0]  sw_cnt_q;
	logic        sw_reading;
	logic [7:0]  sw_cnt_inc;
	logic        sw_acc;
	logic        sw_stable_next;

	logic [1:0]  prior_q;
	logic [31:0] resid_q;
	logic [31:0] press_delta_q;

	logic signed [1:0] step;
	logic [31:0] delta;
	logic [31:0] resid_new;
	logic [31:0] resid_neg;
	logic [31:0] press_delta_new;
	logic [31:0] spc32;
	logic [4:0]  spc;
	logic        cw;
	logic        ccw;
	logic        click;
	logic [4:0]  detent_idx5;

	genvar gi;
	generate
		for (gi = 0; gi < KEY_COUNT; gi++) begin : g_key
			logic [7:0] cnt_inc;
			logic       differs;
			if (gi < 8) begin : g_pin
				assign key_reading[gi] = ~key_levels[gi];
			end else begin : g_none
				assign key_reading[gi] = 1'b0;
			end
			assign differs     = key_reading[gi] != key_stable_q[gi];
			assign cnt_inc     = key_cnt_q[gi] + 8'd1;
			assign key_acc[gi] = scan_tick && differs && (cnt_inc >= stable_ticks);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					key_stable_q[gi] <= 1'b0;
					key_cnt_q[gi]    <= 8'd0;
				end else if (accept && scan_tick) begin
					if (key_acc[gi]) begin
						key_stable_q[gi] <= key_reading[gi];
						key_cnt_q[gi]    <= 8'd0;
					end else if (differs) begin
						key_cnt_q[gi] <= cnt_inc;
					end else begin
						key_cnt_q[gi] <= 8'd0;
					end
				end
			end
		end
	endgenerate

	assign sw_reading     = ~switch_level;
	assign sw_cnt_inc     = sw_cnt_q + 8'd1;
	assign sw_acc         = scan_tick && (sw_reading != sw_stable_q)
		&& (sw_cnt_inc >= stable_ticks);
	assign sw_stable_next = sw_acc ? sw_reading : sw_stable_q;

	// Positive table entry counts down, negative counts up.
	assign step  = kenc_pkg::QUAD_TABLE[{prior_q, phase_a, phase_b}];
	assign delta = (step > 2'sd0) ? 32'hFFFF_FFFF : ((step < 2'sd0) ? 32'd1 : 32'd0);

	assign resid_new       = resid_q + delta;
	assign resid_neg       = 32'd0 - resid_new;
	assign press_delta_new = press_delta_q + delta;

	assign spc   = (steps_per_click == 5'd0) ? 5'd1 : steps_per_click;
	assign spc32 = {27'd0, spc};
	assign cw    = !resid_new[31] && (resid_new >= spc32);
	assign ccw   = resid_new[31] && (resid_neg >= spc32);
	assign click = sw_acc && !sw_reading && (press_delta_new == 32'd0);

	always_comb begin
		detent_idx5 = 5'(KEY_COUNT);
		if (cw) begin
			detent_idx5 = 5'(KEY_COUNT) + (sw_stable_next ? 5'd3 : 5'd0);
		end else begin
			detent_idx5 = 5'(KEY_COUNT) + (sw_stable_next ? 5'd4 : 5'd1);
		end
	end

	always_comb begin
		rec = '0;
		for (int i = 0; i < KEY_COUNT; i++) begin
			rec.key_evt[i]   = key_acc[i];
			rec.key_press[i] = key_reading[i];
		end
		rec.click        = click;
		rec.detent       = cw || ccw;
		rec.detent_index = detent_idx5[3:0];
	end

	assign rec_any = (|key_acc) || click || cw || ccw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_stable_q   <= 1'b0;
			sw_cnt_q      <= 8'd0;
			prior_q       <= 2'd0;
			resid_q       <= 32'd0;
			press_delta_q <= 32'd0;
		end else if (accept) begin
			prior_q <= {phase_a, phase_b};
			if (cw) begin
				resid_q <= resid_new - spc32;
			end else if (ccw) begin
				resid_q <= resid_new + spc32;
			end else begin
				resid_q <= resid_new;
			end
			// Restart the movement check on an accepted press.
			if (sw_acc && sw_reading) begin
				press_delta_q <= 32'd0;
			end else begin
				press_delta_q <= press_delta_new;
			end
			if (scan_tick) begin
				if (sw_acc) begin
					sw_stable_q <= sw_reading;
					sw_cnt_q    <= 8'd0;
				end else if (sw_reading != sw_stable_q) begin
					sw_cnt_q <= sw_cnt_inc;
				end else begin
					sw_cnt_q <= 8'd0;
				end
			end
		end
	end

endmodule

// ===== rtl/core/kenc_fifo.sv =====
// Short record queue between the front and the back.
// Register-based, head read directly. Depends on kenc_pkg.
module kenc_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  kenc_pkg::kenc_rec_t wdata,
	input  logic                pop,
	output kenc_pkg::kenc_rec_t rdata,
	output logic                full,
	output logic                empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	kenc_pkg::kenc_rec_t slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue popped while empty");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !pop) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("queue count did not grow on push");

endmodule

// ===== rtl/core/kenc_back.sv =====
// Back part: serializes one record into events into an output register, one per cycle
// while that register is empty or popped. Depends on kenc_pkg.
module kenc_back #(
	parameter int KEY_COUNT = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kenc_pkg::kenc_rec_t head,
	input  logic                head_empty,
	output logic                head_pop,
	input  logic                pop,
	output logic                out_valid,
	output logic [3:0]          event_index,
	output logic                is_press,
	output logic                last_of_run
);

	localparam logic [4:0] SW_IDX5 = 5'(KEY_COUNT + 2);

	logic [kenc_pkg::MASK_W-1:0]    mask_q;
	logic [kenc_pkg::KEY_SLOTS-1:0] key_press_q;
	logic [3:0]                     detent_index_q;
	logic [kenc_pkg::MASK_W-1:0]    low_bit;
	logic [kenc_pkg::MASK_W-1:0]    rem;
	logic [kenc_pkg::MASK_W-1:0]    head_mask;
	logic [4:0]                     sel;
	logic                           found;
	logic                           advance;
	logic [3:0]                     ev_index;
	logic                           ev_press;

	logic       out_valid_q;
	logic [3:0] event_index_q;
	logic       is_press_q;
	logic       last_q;

	assign head_mask = {head.detent, head.click, head.click, head.key_evt};

	// Lowest pending event goes first.
	always_comb begin
		sel     = '0;
		found   = 1'b0;
		low_bit = '0;
		for (int i = 0; i < kenc_pkg::MASK_W; i++) begin
			if (mask_q[i] && !found) begin
				found      = 1'b1;
				sel        = 5'(i);
				low_bit[i] = 1'b1;
			end
		end
	end

	always_comb begin
		ev_index = sel[3:0];
		ev_press = 1'b1;
		if (sel == 5'(kenc_pkg::MASK_DETENT)) begin
			ev_index = detent_index_q;
		end else if (sel == 5'(kenc_pkg::MASK_CLICK_RELEASE)) begin
			ev_index = SW_IDX5[3:0];
			ev_press = 1'b0;
		end else if (sel == 5'(kenc_pkg::MASK_CLICK_PRESS)) begin
			ev_index = SW_IDX5[3:0];
		end else begin
			ev_press = key_press_q[sel[3:0]];
		end
	end

	assign advance  = found && (!out_valid_q || pop);
	assign rem      = advance ? (mask_q & ~low_bit) : mask_q;
	assign head_pop = (rem == '0) && !head_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			mask_q <= head_pop ? head_mask : rem;
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			key_press_q    <= head.key_press;
			detent_index_q <= head.detent_index;
		end
		if (advance) begin
			event_index_q <= ev_index;
			is_press_q    <= ev_press;
			last_q        <= rem == '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_index = event_index_q;
	assign is_press    = is_press_q;
	assign last_of_run = last_q;

endmodule

// ===== dv/keypad_encoder_event_front_end_tb.sv =====
// Testbench for keypad_encoder_event_front_end: drives pin samples and APB register
// writes, predicts the key, switch and detent events, and checks every result.
// Depends on kenc_pkg and the keypad_encoder_event_front_end RTL.
module keypad_encoder_event_front_end_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEYS        = 8;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE      = 10;

	localparam logic [3:0] EV_CW       = 4'd8;
	localparam logic [3:0] EV_CCW      = 4'd9;
	localparam logic [3:0] EV_SWITCH   = 4'd10;
	localparam logic [3:0] EV_HELD_CW  = 4'd11;
	localparam logic [3:0] EV_HELD_CCW = 4'd12;

	typedef struct packed {
		logic [7:0] keys;
		logic       sw;
		logic       a;
		logic       b;
		logic       tick;
	} pin_sample_t;

	typedef struct packed {
		logic [3:0] index;
		logic       press;
		logic       last;
	} event_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  key_levels = 8'hFF;
	logic        switch_level = 1'b1;
	logic        phase_a = 1'b0;
	logic        phase_b = 1'b0;
	logic        scan_tick = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [3:0]  event_index;
	logic        is_press;
	logic        last_of_run;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	keypad_encoder_event_front_end DUT (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.key_levels(key_levels), .switch_level(switch_level),
		.phase_a(phase_a), .phase_b(phase_b), .scan_tick(scan_tick),
		.empty(empty), .pop(pop),
		.event_index(event_index), .is_press(is_press), .last_of_run(last_of_run),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor state; channel KEYS is the push switch
	logic [7:0]  cfg_debounce = kenc_pkg::STABLE_TICKS_RESET;
	logic [4:0]  cfg_steps = kenc_pkg::STEPS_PER_CLICK_RESET;
	logic [8:0]  held = '0;
	logic [7:0]  chan_cnt [9];
	logic [1:0]  last_phase = 2'b00;
	logic [31:0] enc_count = '0;
	logic [31:0] clicked_count = '0;
	logic [31:0] press_count = '0;

	event_rec_t  expected_events [$];
	event_rec_t  want;
	int          fail_count = 0;
	int          cycles = 0;
	int          pop_wait = 0;
	bit          send_steady = 1'b0;
	bit          recv_steady = 1'b0;

	// Random stimulus state
	logic [7:0]  key_goal = 8'hFF;
	logic        sw_goal = 1'b1;
	logic [1:0]  enc_pos = 2'd0;
	int          enc_mode = 0;

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("keypad_encoder_event_front_end_tb failed");
			$finish;
		end
	end

	function automatic int idle_cycles(input bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic predict_events(input pin_sample_t s);
		event_rec_t  found [$];
		event_rec_t  ev;
		logic [1:0]  move;
		logic        level;
		logic        click;
		logic [31:0] step_size;
		logic [31:0] backlog;
		int          i;
		// position along the Gray cycle 00, 01, 11, 10
		move = {s.a, s.a ^ s.b} - {last_phase[1], last_phase[1] ^ last_phase[0]};
		if (move == 2'd1)
			enc_count = enc_count + 32'd1;
		else if (move == 2'd3)
			enc_count = enc_count - 32'd1;
		last_phase = {s.a, s.b};
		click = 1'b0;
		if (s.tick) begin
			for (i = 0; i <= KEYS; i++) begin
				level = (i < KEYS) ? ~s.keys[i] : ~s.sw;
				if (level != held[i]) begin
					chan_cnt[i] = chan_cnt[i] + 8'd1;
					if (chan_cnt[i] >= cfg_debounce) begin
						held[i] = level;
						chan_cnt[i] = '0;
						if (i < KEYS)
							found.push_back({i[3:0], level, 1'b0});
						else if (level)
							press_count = enc_count;
						else if (enc_count == press_count)
							click = 1'b1;
					end
				end else begin
					chan_cnt[i] = '0;
				end
			end
			if (click) begin
				found.push_back({EV_SWITCH, 1'b1, 1'b0});
				found.push_back({EV_SWITCH, 1'b0, 1'b0});
			end
		end
		step_size = (cfg_steps == 5'd0) ? 32'd1 : {27'd0, cfg_steps};
		backlog = enc_count - clicked_count;
		if (!backlog[31]) begin
			if (backlog >= step_size) begin
				found.push_back({held[KEYS] ? EV_HELD_CW : EV_CW, 1'b1, 1'b0});
				clicked_count = clicked_count + step_size;
			end
		end else if ((32'd0 - backlog) >= step_size) begin
			found.push_back({held[KEYS] ? EV_HELD_CCW : EV_CCW, 1'b1, 1'b0});
			clicked_count = clicked_count - step_size;
		end
		for (i = 0; i < found.size(); i++) begin
			ev = found[i];
			ev.last = (i == found.size() - 1);
			expected_events.push_back(ev);
		end
	endtask

	task automatic send_sample(input pin_sample_t s);
		int gap;
		push <= 1'b1;
		key_levels <= s.keys;
		switch_level <= s.sw;
		phase_a <= s.a;
		phase_b <= s.b;
		scan_tick <= s.tick;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_events(s);
		gap = idle_cycles(send_steady);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off until every predicted event has come out, then let the pipe empty
	task automatic settle();
		push <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic access_reg(input logic idx, input bit do_write, input logic [31:0] value);
		logic [31:0] readback;
		if (do_write) begin
			@(posedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= {idx, 2'b00};
			pwdata <= value;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
			if (idx == kenc_pkg::REG_STABLE_TICKS)
				cfg_debounce = value[7:0];
			else
				cfg_steps = value[4:0];
		end
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		readback = (idx == kenc_pkg::REG_STABLE_TICKS)
			? {24'd0, cfg_debounce} : {27'd0, cfg_steps};
		if (prdata !== readback) begin
			$display("%0t: register %0d readback expected %0h got %0h",
				$time, idx, readback, prdata);
			fail_count++;
		end
	endtask

	task automatic program_settings(input logic [7:0] ticks, input logic [4:0] steps);
		settle();
		access_reg(kenc_pkg::REG_STABLE_TICKS, 1'b1, {24'd0, ticks});
		access_reg(kenc_pkg::REG_STEPS_PER_CLICK, 1'b1, {27'd0, steps});
	endtask

	task automatic test_register_reset();
		access_reg(kenc_pkg::REG_STABLE_TICKS, 1'b0, '0);
		access_reg(kenc_pkg::REG_STEPS_PER_CLICK, 1'b0, '0);
	endtask

	// Reset settings: bounce clears the counter, an unticked sample does not scan,
	// all keys go down together; three quadrature steps stay below one detent.
	task automatic test_key_debounce();
		send_sample({8'h00, 1'b1, 2'b00, 1'b1});
		send_sample({8'h00, 1'b1, 2'b01, 1'b1});
		send_sample({8'hFF, 1'b1, 2'b11, 1'b1});
		send_sample({8'h00, 1'b1, 2'b10, 1'b0});
		repeat (5) send_sample({8'h00, 1'b1, 2'b10, 1'b1});
	endtask

	task automatic test_switch_and_detent();
		program_settings(8'd1, 5'd1);
		// three counts of backlog drain one detent per sample
		send_sample({8'h00, 1'b0, 2'b10, 1'b1});
		// all keys release, switch clicks, detent follows: eleven events
		send_sample({8'hFF, 1'b1, 2'b10, 1'b1});
		send_sample({8'hFF, 1'b1, 2'b10, 1'b0});
		send_sample({8'hFF, 1'b0, 2'b10, 1'b1});
		send_sample({8'hFF, 1'b0, 2'b11, 1'b0});
		// turned while held: no click on release
		send_sample({8'hFF, 1'b1, 2'b11, 1'b1});
		// two-step jump is not counted
		send_sample({8'hFF, 1'b1, 2'b00, 1'b1});
		send_sample({8'hFF, 1'b1, 2'b01, 1'b1});
		send_sample({8'hFF, 1'b1, 2'b00, 1'b1});
	endtask

	// Zero registers: a change passes on the first tick, a detent needs one count
	task automatic test_zero_settings();
		program_settings(8'd0, 5'd0);
		send_sample({8'h55, 1'b1, 2'b00, 1'b1});
		send_sample({8'hAA, 1'b1, 2'b01, 1'b1});
		send_sample({8'hFF, 1'b0, 2'b11, 1'b1});
		send_sample({8'hFF, 1'b1, 2'b11, 1'b1});
	endtask

	task automatic test_long_debounce();
		logic [1:0] pos;
		int         i;
		program_settings(8'd60, 5'd16);
		for (i = 0; i < 64; i++) begin
			pos = 2'd3 - i[1:0];
			send_sample({8'h7F, 1'b1, pos[1], pos[1] ^ pos[0], 1'b1});
		end
	endtask

	task automatic random_sample(output pin_sample_t s);
		int bit_sel;
		bit_sel = $urandom_range(0, 7);
		if ($urandom_range(0, 11) == 0)
			key_goal[bit_sel] = ~key_goal[bit_sel];
		if ($urandom_range(0, 19) == 0)
			sw_goal = ~sw_goal;
		if ($urandom_range(0, 19) == 0)
			enc_mode = $urandom_range(0, 3);
		case (enc_mode)
			1: if ($urandom_range(0, 1)) enc_pos = enc_pos + 2'd1;
			2: if ($urandom_range(0, 1)) enc_pos = enc_pos - 2'd1;
			3: enc_pos = 2'($urandom_range(0, 3));
			default: ;
		endcase
		s.keys = key_goal;
		if ($urandom_range(0, 7) == 0)
			s.keys[$urandom_range(0, 7)] = ~s.keys[$urandom_range(0, 7)];
		s.sw = ($urandom_range(0, 15) == 0) ? ~sw_goal : sw_goal;
		s.a = enc_pos[1];
		s.b = enc_pos[1] ^ enc_pos[0];
		s.tick = ($urandom_range(0, 3) != 0);
		// a few samples of pure noise
		if ($urandom_range(0, 9) == 0)
			{s.keys, s.sw, s.a, s.b, s.tick} = 12'($urandom_range(0, 4095));
	endtask

	task automatic test_random_settings();
		pin_sample_t s;
		int          round;
		int          i;
		for (round = 0; round < 5; round++) begin
			case (round)
				0: program_settings(8'd3, 5'd4);
				1: program_settings(8'd1, 5'd1);
				2: program_settings(8'd0, 5'd0);
				3: program_settings(8'd2, 5'd31);
				default: program_settings(8'd6, 5'd16);
			endcase
			send_steady = ($urandom_range(0, 3) == 0);
			recv_steady = ($urandom_range(0, 3) == 0);
			for (i = 0; i < 35; i++) begin
				random_sample(s);
				send_sample(s);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_events.size() == 0) begin
					$display("%0t: unexpected event index %0d press %0b last %0b",
						$time, event_index, is_press, last_of_run);
					fail_count++;
				end else begin
					want = expected_events.pop_front();
					if (event_index !== want.index) begin
						$display("%0t: event_index expected %0d got %0d",
							$time, want.index, event_index);
						fail_count++;
					end
					if (is_press !== want.press) begin
						$display("%0t: is_press expected %0b got %0b",
							$time, want.press, is_press);
						fail_count++;
					end
					if (last_of_run !== want.last) begin
						$display("%0t: last_of_run expected %0b got %0b",
							$time, want.last, last_of_run);
						fail_count++;
					end
				end
			end
			if (pop_wait > 0) begin
				pop <= 1'b0;
				pop_wait--;
			end else begin
				pop <= 1'b1;
				pop_wait = idle_cycles(recv_steady);
			end
		end
	end

	initial begin
		for (int i = 0; i <= KEYS; i++)
			chan_cnt[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_register_reset();
		test_key_debounce();
		test_switch_and_detent();
		test_zero_settings();
		test_long_debounce();
		test_random_settings();
		settle();
		if (expected_events.size() == 0 && fail_count == 0) begin
			$display("keypad_encoder_event_front_end_tb passed");
		end else begin
			$display("keypad_encoder_event_front_end_tb failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/kenc_pkg.sv
rtl/core/kenc_front.sv
rtl/core/kenc_fifo.sv
rtl/core/kenc_back.sv
rtl/core/keypad_encoder_event_front_end.sv
dv/keypad_encoder_event_front_end_tb.sv
